/* rtl/circ_pkg.sv */
package circ_pkg;

  localparam int unsigned THR_W      = 40;
  localparam logic [THR_W-1:0] THR_RESET = 40'd4295;
  localparam int unsigned QB         = 34;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;
  localparam logic        REG_THRESHOLD = 1'b0;

  typedef logic signed [31:0] coord_t;
  typedef logic signed [32:0] diff_t;
  typedef logic signed [66:0] cross_t;
  typedef logic        [66:0] mag_t;

  typedef struct packed {
    logic   coll;
    coord_t p1x;
    coord_t p1y;
  } side_t;

  typedef struct packed {
    side_t  side;
    diff_t  sumx;
    diff_t  sumy;
    diff_t  vx;
    diff_t  vy;
    cross_t vu;
    cross_t nm;
    mag_t   mag;
  } item_t;

  typedef struct packed {
    side_t         side;
    logic [QB-1:0] qx;
    logic [QB-1:0] qy;
    logic          negx;
    logic          negy;
    logic          ovfx;
    logic          ovfy;
  } cent_t;

  typedef struct packed {
    logic        valid_res;
    coord_t      center_x;
    coord_t      center_y;
    logic [30:0] radius;
    logic        saturated;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

/* rtl/circ_front.sv */
module circ_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       in_valid_i,
  input  logic [191:0]               in_data_i,
  input  logic [circ_pkg::THR_W-1:0] thr_i,
  output logic                       out_valid_o,
  output circ_pkg::item_t            item_o
);

  typedef struct packed {
    circ_pkg::diff_t  ux;
    circ_pkg::diff_t  uy;
    circ_pkg::diff_t  vx;
    circ_pkg::diff_t  vy;
    circ_pkg::diff_t  ax;
    circ_pkg::diff_t  ay;
    circ_pkg::diff_t  sumx;
    circ_pkg::diff_t  sumy;
    circ_pkg::coord_t p1x;
    circ_pkg::coord_t p1y;
  } s0_t;

  typedef struct packed {
    logic signed [65:0] m1;
    logic signed [65:0] m2;
    logic signed [65:0] m3;
    logic signed [65:0] m4;
    circ_pkg::diff_t    vx;
    circ_pkg::diff_t    vy;
    circ_pkg::diff_t    sumx;
    circ_pkg::diff_t    sumy;
    circ_pkg::coord_t   p1x;
    circ_pkg::coord_t   p1y;
  } s1_t;

  circ_pkg::coord_t p1x, p1y, p2x, p2y, p3x, p3y;
  s0_t             s0_d, s0_q;
  s1_t             s1_d, s1_q;
  circ_pkg::item_t s2_d, s2_q, s3_d, s3_q, s4_d, s4_q;
  logic [4:0]      vld_q;

  assign p1x = circ_pkg::coord_t'(in_data_i[31:0]);
  assign p1y = circ_pkg::coord_t'(in_data_i[63:32]);
  assign p2x = circ_pkg::coord_t'(in_data_i[95:64]);
  assign p2y = circ_pkg::coord_t'(in_data_i[127:96]);
  assign p3x = circ_pkg::coord_t'(in_data_i[159:128]);
  assign p3y = circ_pkg::coord_t'(in_data_i[191:160]);

  always_comb begin
    s0_d.ux   = circ_pkg::diff_t'(p1y) - circ_pkg::diff_t'(p2y);
    s0_d.uy   = circ_pkg::diff_t'(p2x) - circ_pkg::diff_t'(p1x);
    s0_d.vx   = circ_pkg::diff_t'(p2y) - circ_pkg::diff_t'(p3y);
    s0_d.vy   = circ_pkg::diff_t'(p3x) - circ_pkg::diff_t'(p2x);
    s0_d.ax   = circ_pkg::diff_t'(p1x) - circ_pkg::diff_t'(p3x);
    s0_d.ay   = circ_pkg::diff_t'(p1y) - circ_pkg::diff_t'(p3y);
    s0_d.sumx = circ_pkg::diff_t'(p2x) + circ_pkg::diff_t'(p3x);
    s0_d.sumy = circ_pkg::diff_t'(p2y) + circ_pkg::diff_t'(p3y);
    s0_d.p1x  = p1x;
    s0_d.p1y  = p1y;
  end

  always_comb begin
    s1_d.m1   = s0_q.vx * s0_q.uy;
    s1_d.m2   = s0_q.vy * s0_q.ux;
    s1_d.m3   = s0_q.ax * s0_q.uy;
    s1_d.m4   = s0_q.ay * s0_q.ux;
    s1_d.vx   = s0_q.vx;
    s1_d.vy   = s0_q.vy;
    s1_d.sumx = s0_q.sumx;
    s1_d.sumy = s0_q.sumy;
    s1_d.p1x  = s0_q.p1x;
    s1_d.p1y  = s0_q.p1y;
  end

  always_comb begin
    s2_d           = '0;
    s2_d.vu        = circ_pkg::cross_t'(s1_q.m1) - circ_pkg::cross_t'(s1_q.m2);
    s2_d.nm        = circ_pkg::cross_t'(s1_q.m3) - circ_pkg::cross_t'(s1_q.m4);
    s2_d.vx        = s1_q.vx;
    s2_d.vy        = s1_q.vy;
    s2_d.sumx      = s1_q.sumx;
    s2_d.sumy      = s1_q.sumy;
    s2_d.side.p1x  = s1_q.p1x;
    s2_d.side.p1y  = s1_q.p1y;
  end

  always_comb begin
    s3_d     = s2_q;
    s3_d.mag = s2_q.vu[66] ? circ_pkg::mag_t'(-s2_q.vu) : circ_pkg::mag_t'(s2_q.vu);
  end

  always_comb begin
    s4_d           = s3_q;
    s4_d.side.coll = (s3_q.mag == '0) ||
                     ((s3_q.mag[66:circ_pkg::THR_W] == '0) &&
                      (s3_q.mag[circ_pkg::THR_W-1:0] < thr_i));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s0_q <= s0_d;
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], in_valid_i};
    end
  end

  assign out_valid_o = vld_q[4];
  assign item_o      = s4_q;

endmodule

/* rtl/circ_fifo.sv */
module circ_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  circ_pkg::item_t        data_i,
  input  logic                   pop_i,
  output circ_pkg::item_t        data_o,
  output circ_pkg::fifo_stat_t   stat_o
);

  circ_pkg::item_t                mem_q [circ_pkg::FIFO_DEPTH];
  logic [circ_pkg::FIFO_AW-1:0]   wptr_q, rptr_q;
  logic [circ_pkg::FIFO_AW:0]     cnt_q, cnt_d;
  logic                           do_push, do_pop;

  assign stat_o.full  = (cnt_q == (circ_pkg::FIFO_AW+1)'(circ_pkg::FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i & ~stat_o.full;
  assign do_pop       = pop_i & ~stat_o.empty;
  assign data_o       = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (circ_pkg::FIFO_AW+1)'(circ_pkg::FIFO_DEPTH))
    else $error("queue count beyond depth");

  a_cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count missed a push");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wptr_q - rptr_q) == cnt_q[circ_pkg::FIFO_AW-1:0])
    else $error("queue pointers disagree with count");

endmodule

/* rtl/circ_center.sv */
module circ_center (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            in_valid_i,
  input  circ_pkg::item_t item_i,
  output logic            out_valid_o,
  output circ_pkg::cent_t cent_o
);

  localparam int unsigned NV = 6 + circ_pkg::QB;

  typedef logic signed [99:0]  prod_t;
  typedef logic signed [100:0] num_t;
  typedef logic        [103:0] dv_t;

  typedef struct packed {
    circ_pkg::side_t    side;
    logic signed [67:0] alx, blx, aly, bly;
    logic signed [65:0] ahx, bhx, ahy, bhy;
    logic               vus;
    circ_pkg::mag_t     mag;
  } c0_t;

  typedef struct packed {
    circ_pkg::side_t side;
    prod_t           pax, pbx, pay, pby;
    logic            vus;
    circ_pkg::mag_t  mag;
  } c1_t;

  typedef struct packed {
    circ_pkg::side_t side;
    num_t            nx, ny;
    logic            vus;
    circ_pkg::mag_t  mag;
  } c2_t;

  typedef struct packed {
    circ_pkg::side_t side;
    logic [99:0]     abx, aby;
    logic            negx, negy;
    circ_pkg::mag_t  mag;
  } c3_t;

  typedef struct packed {
    circ_pkg::side_t         side;
    dv_t                     rx, ry;
    logic [68:0]             d;
    logic [circ_pkg::QB-1:0] qx, qy;
    logic                    negx, negy, ovfx, ovfy;
  } dvs_t;

  logic signed [34:0] vl, nl;
  logic signed [32:0] vh, nh;
  c0_t                c0_d, c0_q;
  c1_t                c1_d, c1_q;
  c2_t                c2_d, c2_q;
  c3_t                c3_d, c3_q;
  dvs_t               c4_d, c4_q, c5_d;
  dvs_t               dv_q [circ_pkg::QB+1];
  logic [NV-1:0]      vld_q;

  always_comb begin
    vl        = $signed({1'b0, item_i.vu[33:0]});
    vh        = item_i.vu[66:34];
    nl        = $signed({1'b0, item_i.nm[33:0]});
    nh        = item_i.nm[66:34];
    c0_d.side = item_i.side;
    c0_d.alx  = item_i.sumx * vl;
    c0_d.ahx  = item_i.sumx * vh;
    c0_d.blx  = item_i.vx * nl;
    c0_d.bhx  = item_i.vx * nh;
    c0_d.aly  = item_i.sumy * vl;
    c0_d.ahy  = item_i.sumy * vh;
    c0_d.bly  = item_i.vy * nl;
    c0_d.bhy  = item_i.vy * nh;
    c0_d.vus  = item_i.vu[66];
    c0_d.mag  = item_i.mag;
  end

  always_comb begin
    c1_d.side = c0_q.side;
    c1_d.pax  = (prod_t'(c0_q.ahx) <<< 34) + prod_t'(c0_q.alx);
    c1_d.pbx  = (prod_t'(c0_q.bhx) <<< 34) + prod_t'(c0_q.blx);
    c1_d.pay  = (prod_t'(c0_q.ahy) <<< 34) + prod_t'(c0_q.aly);
    c1_d.pby  = (prod_t'(c0_q.bhy) <<< 34) + prod_t'(c0_q.bly);
    c1_d.vus  = c0_q.vus;
    c1_d.mag  = c0_q.mag;
  end

  always_comb begin
    c2_d.side = c1_q.side;
    c2_d.nx   = num_t'(c1_q.pax) + num_t'(c1_q.pbx);
    c2_d.ny   = num_t'(c1_q.pay) + num_t'(c1_q.pby);
    c2_d.vus  = c1_q.vus;
    c2_d.mag  = c1_q.mag;
  end

  always_comb begin
    c3_d.side = c2_q.side;
    c3_d.abx  = c2_q.nx[100] ? 100'(-c2_q.nx) : 100'(c2_q.nx);
    c3_d.aby  = c2_q.ny[100] ? 100'(-c2_q.ny) : 100'(c2_q.ny);
    c3_d.negx = c2_q.nx[100] ^ c2_q.vus;
    c3_d.negy = c2_q.ny[100] ^ c2_q.vus;
    c3_d.mag  = c2_q.mag;
  end

  // rounded quotient: (2|n| + |d|) / (2|d|), d = 2*vu
  always_comb begin
    c4_d      = '0;
    c4_d.side = c3_q.side;
    c4_d.rx   = dv_t'({c3_q.abx, 1'b0}) + dv_t'({c3_q.mag, 1'b0});
    c4_d.ry   = dv_t'({c3_q.aby, 1'b0}) + dv_t'({c3_q.mag, 1'b0});
    c4_d.d    = {c3_q.mag, 2'b00};
    c4_d.negx = c3_q.negx;
    c4_d.negy = c3_q.negy;
  end

  always_comb begin
    c5_d      = c4_q;
    c5_d.ovfx = c4_q.rx >= (dv_t'(c4_q.d) << circ_pkg::QB);
    c5_d.ovfy = c4_q.ry >= (dv_t'(c4_q.d) << circ_pkg::QB);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c0_q     <= c0_d;
      c1_q     <= c1_d;
      c2_q     <= c2_d;
      c3_q     <= c3_d;
      c4_q     <= c4_d;
      dv_q[0]  <= c5_d;
    end
  end

  for (genvar k = 0; k < circ_pkg::QB; k++) begin : g_div
    localparam int unsigned Sh = circ_pkg::QB - 1 - k;
    dvs_t st_d;
    dv_t  trial;

    always_comb begin
      trial   = dv_t'(dv_q[k].d) << Sh;
      st_d    = dv_q[k];
      st_d.qx = {dv_q[k].qx[circ_pkg::QB-2:0], 1'b0};
      st_d.qy = {dv_q[k].qy[circ_pkg::QB-2:0], 1'b0};
      if (dv_q[k].rx >= trial) begin
        st_d.rx    = dv_q[k].rx - trial;
        st_d.qx[0] = 1'b1;
      end
      if (dv_q[k].ry >= trial) begin
        st_d.ry    = dv_q[k].ry - trial;
        st_d.qy[0] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_q[k+1] <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NV-2:0], in_valid_i};
    end
  end

  assign out_valid_o = vld_q[NV-1];
  assign cent_o.side = dv_q[circ_pkg::QB].side;
  assign cent_o.qx   = dv_q[circ_pkg::QB].qx;
  assign cent_o.qy   = dv_q[circ_pkg::QB].qy;
  assign cent_o.negx = dv_q[circ_pkg::QB].negx;
  assign cent_o.negy = dv_q[circ_pkg::QB].negy;
  assign cent_o.ovfx = dv_q[circ_pkg::QB].ovfx;
  assign cent_o.ovfy = dv_q[circ_pkg::QB].ovfy;

endmodule

/* rtl/circ_radius.sv */
module circ_radius (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            in_valid_i,
  input  circ_pkg::cent_t cent_i,
  output logic            out_valid_o,
  output circ_pkg::res_t  res_o
);

  localparam int unsigned RB = 32;
  localparam int unsigned NV = 5 + RB;
  localparam logic [31:0] CoordMax = 32'h7FFF_FFFF;
  localparam logic [31:0] CoordMin = 32'h8000_0000;
  localparam logic [63:0] RadMax   = 64'h0000_0000_7FFF_FFFF;

  typedef logic signed [34:0] cx_t;
  typedef logic signed [35:0] dd_t;

  typedef struct packed {
    circ_pkg::side_t side;
    cx_t             cx, cy;
    logic            negx, negy, ovfx, ovfy;
  } r0_t;

  typedef struct packed {
    logic             coll;
    circ_pkg::coord_t cxo, cyo;
    logic             csat;
    dd_t              ddx, ddy;
    logic             ovf;
  } r1_t;

  typedef struct packed {
    logic             coll;
    circ_pkg::coord_t cxo, cyo;
    logic             csat, rsat;
    logic [30:0]      dx, dy;
  } r2_t;

  typedef struct packed {
    logic             coll;
    circ_pkg::coord_t cxo, cyo;
    logic             csat, rsat;
    logic [61:0]      sqx, sqy;
  } r3_t;

  typedef struct packed {
    logic             coll;
    circ_pkg::coord_t cxo, cyo;
    logic             csat, rsat;
    logic [63:0]      rem, root;
  } sq_t;

  function automatic logic [32:0] clip(cx_t v, logic ovf, logic neg);
    logic [32:0] r;
    if (ovf) begin
      r = {1'b1, neg ? CoordMin : CoordMax};
    end else if (v[34:31] != 4'b0000 && v[34:31] != 4'b1111) begin
      r = {1'b1, v[34] ? CoordMin : CoordMax};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  cx_t            qsx, qsy;
  logic [32:0]    clx, cly;
  logic [35:0]    adx, ady;
  r0_t            r0_d, r0_q;
  r1_t            r1_d, r1_q;
  r2_t            r2_d, r2_q;
  r3_t            r3_d, r3_q;
  sq_t            sq0_d;
  sq_t            sq_q [RB+1];
  logic [63:0]    rr;
  logic           rsat_f;
  circ_pkg::res_t res_d, res_q;
  logic [NV-1:0]  vld_q;
  logic           out_valid_q;

  always_comb begin
    qsx       = $signed({1'b0, cent_i.qx});
    qsy       = $signed({1'b0, cent_i.qy});
    r0_d.side = cent_i.side;
    r0_d.cx   = cent_i.negx ? -qsx : qsx;
    r0_d.cy   = cent_i.negy ? -qsy : qsy;
    r0_d.negx = cent_i.negx;
    r0_d.negy = cent_i.negy;
    r0_d.ovfx = cent_i.ovfx;
    r0_d.ovfy = cent_i.ovfy;
  end

  always_comb begin
    clx       = clip(r0_q.cx, r0_q.ovfx, r0_q.negx);
    cly       = clip(r0_q.cy, r0_q.ovfy, r0_q.negy);
    r1_d.coll = r0_q.side.coll;
    r1_d.cxo  = circ_pkg::coord_t'(clx[31:0]);
    r1_d.cyo  = circ_pkg::coord_t'(cly[31:0]);
    r1_d.csat = clx[32] | cly[32];
    r1_d.ddx  = dd_t'(r0_q.cx) - dd_t'(r0_q.side.p1x);
    r1_d.ddy  = dd_t'(r0_q.cy) - dd_t'(r0_q.side.p1y);
    r1_d.ovf  = r0_q.ovfx | r0_q.ovfy;
  end

  always_comb begin
    adx       = r1_q.ddx[35] ? -r1_q.ddx : r1_q.ddx;
    ady       = r1_q.ddy[35] ? -r1_q.ddy : r1_q.ddy;
    r2_d.coll = r1_q.coll;
    r2_d.cxo  = r1_q.cxo;
    r2_d.cyo  = r1_q.cyo;
    r2_d.csat = r1_q.csat;
    r2_d.rsat = r1_q.ovf | (|adx[35:31]) | (|ady[35:31]);
    r2_d.dx   = adx[30:0];
    r2_d.dy   = ady[30:0];
  end

  always_comb begin
    r3_d.coll = r2_q.coll;
    r3_d.cxo  = r2_q.cxo;
    r3_d.cyo  = r2_q.cyo;
    r3_d.csat = r2_q.csat;
    r3_d.rsat = r2_q.rsat;
    r3_d.sqx  = r2_q.dx * r2_q.dx;
    r3_d.sqy  = r2_q.dy * r2_q.dy;
  end

  always_comb begin
    sq0_d.coll = r3_q.coll;
    sq0_d.cxo  = r3_q.cxo;
    sq0_d.cyo  = r3_q.cyo;
    sq0_d.csat = r3_q.csat;
    sq0_d.rsat = r3_q.rsat;
    sq0_d.rem  = 64'(r3_q.sqx) + 64'(r3_q.sqy);
    sq0_d.root = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r0_q     <= r0_d;
      r1_q     <= r1_d;
      r2_q     <= r2_d;
      r3_q     <= r3_d;
      sq_q[0]  <= sq0_d;
    end
  end

  // one root bit per stage
  for (genvar k = 0; k < RB; k++) begin : g_sqrt
    localparam int unsigned Sh = 62 - 2 * k;
    sq_t         st_d;
    logic [63:0] trial;

    always_comb begin
      trial   = sq_q[k].root + (64'd1 << Sh);
      st_d    = sq_q[k];
      if (sq_q[k].rem >= trial) begin
        st_d.rem  = sq_q[k].rem - trial;
        st_d.root = (sq_q[k].root >> 1) + (64'd1 << Sh);
      end else begin
        st_d.root = sq_q[k].root >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_q[k+1] <= st_d;
      end
    end
  end

  always_comb begin
    rr     = (sq_q[RB].rem > sq_q[RB].root) ? sq_q[RB].root + 64'd1 : sq_q[RB].root;
    rsat_f = sq_q[RB].rsat | (rr > RadMax);
    res_d  = '0;
    if (!sq_q[RB].coll) begin
      res_d.valid_res = 1'b1;
      res_d.center_x  = sq_q[RB].cxo;
      res_d.center_y  = sq_q[RB].cyo;
      res_d.radius    = rsat_f ? RadMax[30:0] : rr[30:0];
      res_d.saturated = sq_q[RB].csat | rsat_f;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      vld_q       <= {vld_q[NV-2:0], in_valid_i};
      out_valid_q <= vld_q[NV-1];
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

/* rtl/circumcircle_from_three_points_core.sv */
// channel      | direction | handshake                     | payload
// s_axis       | in        | s_axis_tvalid / s_axis_tready | point triple
// m_axis       | out       | m_axis_tvalid / m_axis_tready | circle, tuser = valid_res
// apb          | in        | psel / penable / pready       | collinear_threshold at 0x0
//
// one item per cycle while m_axis does not stall; the back holds the 34-step divider
// and the 32-step square root pipelines
// reset is asynchronous and clears all valid bits; collinear_threshold resets to 4295
// a stall on m_axis freezes the back; the front keeps taking items until the
// four-entry queue is full, then drops s_axis_tready
module circumcircle_from_three_points_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // first_x, first_y, second_x, second_y, third_x, third_y
  input  logic [191:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // center_x, center_y, radius, saturated
  output logic [95:0]  m_axis_tdata,
  // valid_res
  output logic [0:0]   m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  logic [circ_pkg::THR_W-1:0] thr_q;
  logic                       en_f, en_b, push, pop;
  logic                       front_valid, cent_valid, res_valid;
  circ_pkg::item_t            front_item, fifo_item;
  circ_pkg::fifo_stat_t       fifo_stat;
  circ_pkg::cent_t            cent;
  circ_pkg::res_t             res;

  assign pready = 1'b1;
  assign prdata = (paddr[3] == circ_pkg::REG_THRESHOLD) ? 64'(thr_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= circ_pkg::THR_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[3] == circ_pkg::REG_THRESHOLD)) begin
      thr_q <= pwdata[circ_pkg::THR_W-1:0];
    end
  end

  assign en_f          = ~fifo_stat.full;
  assign s_axis_tready = en_f;
  assign push          = en_f & front_valid;
  assign en_b          = ~res_valid | m_axis_tready;
  assign pop           = en_b & ~fifo_stat.empty;

  circ_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en_f),
    .in_valid_i  (s_axis_tvalid),
    .in_data_i   (s_axis_tdata),
    .thr_i       (thr_q),
    .out_valid_o (front_valid),
    .item_o      (front_item)
  );

  circ_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (front_item),
    .pop_i  (pop),
    .data_o (fifo_item),
    .stat_o (fifo_stat)
  );

  circ_center u_center (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en_b),
    .in_valid_i  (pop),
    .item_i      (fifo_item),
    .out_valid_o (cent_valid),
    .cent_o      (cent)
  );

  circ_radius u_radius (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en_b),
    .in_valid_i  (cent_valid),
    .cent_i      (cent),
    .out_valid_o (res_valid),
    .res_o       (res)
  );

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {res.saturated, res.radius, res.center_y, res.center_x};
  assign m_axis_tuser  = res.valid_res;

endmodule
